[rtl/sil_pkg.sv]
// Shared constants and field widths for the sorted insert list.
`default_nettype none

package sil_pkg;

   // Field widths of the request and response transfers.
   localparam int unsigned ValueWidth    = 32;
   localparam int unsigned PositionWidth = 4;
   localparam int unsigned CountWidth    = 5;
   localparam int unsigned StatusWidth   = 2;

   typedef logic [StatusWidth-1:0] status_type;

   // Request command codes.
   localparam logic CMD_INSERT   = 1'b0;
   localparam logic CMD_READ_OUT = 1'b1;

   // Response status codes.
   localparam status_type STATUS_INSERTED = 2'd0;
   localparam status_type STATUS_FULL     = 2'd1;
   localparam status_type STATUS_ELEMENT  = 2'd2;
   localparam status_type STATUS_EMPTY    = 2'd3;

endpackage

`default_nettype wire

[rtl/sorted_insert_list.sv]
// Sorted insert list: keeps signed values in ascending order in a single RAM.
// An insert compares the new value with the stored ones from the top down and shifts each
// greater entry up, one per cycle, before it writes the new value and answers.
// A read-out gives one response per stored value, one per cycle while the consumer is
// ready; an empty read-out or an insert into a full list gives a single response.
// One command is worked on at a time. Reset empties the list and drops any pending
// response; the RAM contents are not cleared, as only filled entries are ever read.
`default_nettype none

module sorted_insert_list
   import sil_pkg::*;
#(
   parameter int unsigned CAPACITY = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic                     req_command,
   input  wire logic signed [31:0]       req_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [31:0]            rsp_value_out,
   output logic [PositionWidth-1:0]      rsp_position,
   output logic [CountWidth-1:0]         rsp_count,
   output logic [StatusWidth-1:0]        rsp_status,
   output logic                          rsp_last
);

   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned XW = (CW > CountWidth) ? CW : CountWidth;

   // Sequencer states.
   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_INS_CMP = 3'd1;
   localparam logic [2:0] ST_INS_PUT = 3'd2;
   localparam logic [2:0] ST_FULL    = 3'd3;
   localparam logic [2:0] ST_EMPTY   = 3'd4;
   localparam logic [2:0] ST_RD_DATA = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     fill_ff, fill_in;
   logic signed [31:0] val_ff, val_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_value_ff, rsp_value_in;
   logic [PositionWidth-1:0] rsp_position_ff, rsp_position_in;
   logic [CountWidth-1:0]    rsp_count_ff, rsp_count_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [31:0]       ram_wdata;
   logic              ram_re;
   logic [AW-1:0]     ram_raddr;
   logic [31:0]       ram_rdata;

   logic              out_free;
   logic              rsp_load;
   logic              req_xfer;
   logic [CW-1:0]     fill_inc;
   logic [CW-1:0]     idx_inc;
   logic [XW-1:0]     idx_wide;
   logic [XW-1:0]     fill_wide;
   logic [XW-1:0]     fill_inc_wide;

   sil_ram #(
      .WIDTH (ValueWidth),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_ready     = (state_ff == ST_IDLE);
   assign req_xfer      = req_valid && req_ready;
   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign fill_inc      = fill_ff + CW'(1);
   assign idx_inc       = CW'(idx_ff) + CW'(1);
   assign idx_wide      = XW'(idx_ff);
   assign fill_wide     = XW'(fill_ff);
   assign fill_inc_wide = XW'(fill_inc);

   // Command sequencer: read, compare and shift through the RAM.
   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      fill_in         = fill_ff;
      val_in          = val_ff;
      ram_we          = 1'b0;
      ram_waddr       = idx_ff;
      ram_wdata       = val_ff;
      ram_re          = 1'b0;
      ram_raddr       = '0;
      rsp_load        = 1'b0;
      rsp_value_in    = rsp_value_ff;
      rsp_position_in = rsp_position_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_last_in     = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               val_in = req_value;
               if (req_command == CMD_INSERT) begin
                  if (fill_ff == CW'(CAPACITY)) begin
                     state_in = ST_FULL;
                  end else if (fill_ff == '0) begin
                     idx_in   = '0;
                     state_in = ST_INS_PUT;
                  end else begin
                     // Start from the top entry and work downwards.
                     idx_in    = AW'(fill_ff);
                     ram_re    = 1'b1;
                     ram_raddr = AW'(fill_ff - CW'(1));
                     state_in  = ST_INS_CMP;
                  end
               end else begin
                  if (fill_ff == '0) begin
                     state_in = ST_EMPTY;
                  end else begin
                     idx_in    = '0;
                     ram_re    = 1'b1;
                     ram_raddr = '0;
                     state_in  = ST_RD_DATA;
                  end
               end
            end
         end
         ST_INS_CMP: begin
            // The entry below idx is in the read register.
            if (val_ff < $signed(ram_rdata)) begin
               ram_we    = 1'b1;
               ram_waddr = idx_ff;
               ram_wdata = ram_rdata;
               idx_in    = idx_ff - AW'(1);
               if (idx_ff == AW'(1)) begin
                  state_in = ST_INS_PUT;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = idx_ff - AW'(2);
               end
            end else begin
               state_in = ST_INS_PUT;
            end
         end
         ST_INS_PUT: begin
            if (out_free) begin
               ram_we          = 1'b1;
               ram_waddr       = idx_ff;
               ram_wdata       = val_ff;
               fill_in         = fill_inc;
               rsp_load        = 1'b1;
               rsp_value_in    = '0;
               rsp_position_in = idx_wide[PositionWidth-1:0];
               rsp_count_in    = fill_inc_wide[CountWidth-1:0];
               rsp_status_in   = STATUS_INSERTED;
               rsp_last_in     = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_FULL: begin
            if (out_free) begin
               rsp_load        = 1'b1;
               rsp_value_in    = '0;
               rsp_position_in = '0;
               rsp_count_in    = fill_wide[CountWidth-1:0];
               rsp_status_in   = STATUS_FULL;
               rsp_last_in     = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               rsp_load        = 1'b1;
               rsp_value_in    = '0;
               rsp_position_in = '0;
               rsp_count_in    = '0;
               rsp_status_in   = STATUS_EMPTY;
               rsp_last_in     = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_RD_DATA: begin
            // One element per cycle; the read data holds while the output stalls.
            if (out_free) begin
               rsp_load        = 1'b1;
               rsp_value_in    = ram_rdata;
               rsp_position_in = idx_wide[PositionWidth-1:0];
               rsp_count_in    = fill_wide[CountWidth-1:0];
               rsp_status_in   = STATUS_ELEMENT;
               rsp_last_in     = (idx_inc == fill_ff);
               if (idx_inc == fill_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in    = idx_ff + AW'(1);
                  ram_re    = 1'b1;
                  ram_raddr = idx_ff + AW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register valid: set on load, cleared when the transfer completes.
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff          <= idx_in;
      val_ff          <= val_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_position_ff <= rsp_position_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = $signed(rsp_value_ff);
   assign rsp_position  = rsp_position_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

   // The fill count never passes the capacity.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(CAPACITY))
      else $error("fill count above capacity");

   // A new response is only loaded when the previous one has gone or is leaving.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("pending response overwritten");

   // The RAM is never written while the block waits for a command.
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !ram_we)
      else $error("RAM written while idle");

   // A completed insert grows the list by exactly one entry.
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_status_in == STATUS_INSERTED) |=> (fill_ff == $past(fill_ff) + CW'(1)))
      else $error("insert did not grow the list");

   // A full or empty answer leaves the fill count unchanged.
   a_no_change: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FULL || state_ff == ST_EMPTY) |=> $stable(fill_ff))
      else $error("fill count changed on full or empty answer");

endmodule

`default_nettype wire

[rtl/sil_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module sil_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
